// ===== hw/rtl/hamming_7_4_char_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Hamming(7,4) character deframer
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef HAMMING_7_4_CHAR_DEFRAMER_MACROS_SVH
`define HAMMING_7_4_CHAR_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define H74CD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("h74cd assertion failed");
// Next-cycle implication
`define H74CD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("h74cd assertion failed");
`else
`define H74CD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define H74CD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/h74cd_pkg.sv =====
// ----------------------------------------------------------------------------
// h74cd_pkg
// Types and constants shared by the Hamming(7,4) character deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package h74cd_pkg;

  localparam int CODE_BITS = 7;
  localparam int DATA_BITS = 4;
  localparam int CHAR_BITS = 2 * DATA_BITS;

  localparam logic [CHAR_BITS-1:0] LOW_LIMIT_RESET  = 8'd32;
  localparam logic [CHAR_BITS-1:0] HIGH_LIMIT_RESET = 8'd127;

  // Configuration register index
  typedef enum logic [0:0] {
    REG_CHAR_LOW  = 1'b0,
    REG_CHAR_HIGH = 1'b1
  } cfg_reg_t;

  typedef logic [CODE_BITS-1:0] code_word_t;
  typedef logic [DATA_BITS-1:0] nibble_t;
  typedef logic [CHAR_BITS-1:0] char_t;

  // One input request
  typedef struct packed {
    logic code_bit;
    logic line_end;
  } item_t;

  // One result request
  typedef struct packed {
    logic  char_valid;
    char_t out_char;
    logic  line_done;
    logic  line_error;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/h74cd_if.sv =====
// ----------------------------------------------------------------------------
// h74cd_in_if / h74cd_out_if
// Valid/ready channels carrying code bits in and decoded results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface h74cd_in_if;
  logic valid;
  logic ready;
  logic code_bit;
  logic line_end;

  modport source (output valid, output code_bit, output line_end, input ready);
  modport sink (input valid, input code_bit, input line_end, output ready);
endinterface

interface h74cd_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] out_char;
  logic       line_done;
  logic       line_error;

  modport source (output valid, output char_valid, output out_char,
                  output line_done, output line_error, input ready);
  modport sink (input valid, input char_valid, input out_char,
                input line_done, input line_error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/h74cd_decode.sv =====
// ----------------------------------------------------------------------------
// h74cd_decode
// Hamming(7,4) syndrome decoder: corrects one bit, extracts d1..d4.
// ----------------------------------------------------------------------------
`default_nettype none

module h74cd_decode
  import h74cd_pkg::*;
(
  input  code_word_t word_i,   // position 1 in the MSB
  output nibble_t    nibble_o
);

  logic [2:0] syn;
  code_word_t flip;
  code_word_t fixed;

  // Position p sits at bit (7 - p); syndrome is the XOR of set positions
  assign syn[0] = word_i[6] ^ word_i[4] ^ word_i[2] ^ word_i[0];
  assign syn[1] = word_i[5] ^ word_i[4] ^ word_i[1] ^ word_i[0];
  assign syn[2] = word_i[3] ^ word_i[2] ^ word_i[1] ^ word_i[0];

  // Flip the named position; a zero syndrome matches no bit
  always_comb begin
    for (int i = 0; i < CODE_BITS; i++) begin
      flip[i] = (syn == 3'(CODE_BITS - i));
    end
  end

  assign fixed    = word_i ^ flip;
  assign nibble_o = {fixed[4], fixed[2], fixed[1], fixed[0]};

endmodule

`default_nettype wire

// ===== hw/rtl/h74cd_framer.sv =====
// ----------------------------------------------------------------------------
// h74cd_framer
// Line state: bit assembly, nibble pairing, range check and line error.
// ----------------------------------------------------------------------------
`default_nettype none

module h74cd_framer
  import h74cd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_i,       // consume item_i and update state
  input  item_t   item_i,
  input  char_t   low_limit_i,
  input  char_t   high_limit_i,
  output logic    has_result_o,
  output result_t result_o
);

  logic [CODE_BITS-2:0] bit_shift_r, bit_shift_nxt;
  logic [2:0]           bit_count_r, bit_count_nxt;
  nibble_t              high_nibble_r, high_nibble_nxt;
  logic                 pending_r, pending_nxt;
  logic                 error_r, error_nxt;

  code_word_t word;
  logic [2:0] count_inc;
  logic       word_done;
  nibble_t    nib;
  char_t      ch;
  logic       char_formed;
  logic       in_range;
  logic       emit;
  logic       err_set;

  // Assemble the codeword with the incoming bit
  assign word      = {bit_shift_r, item_i.code_bit};
  assign count_inc = bit_count_r + 3'd1;
  assign word_done = (count_inc == 3'(CODE_BITS));

  h74cd_decode u_decode (
    .word_i   (word),
    .nibble_o (nib)
  );

  // Pair nibbles and check the character range
  assign ch          = {high_nibble_r, nib};
  assign char_formed = word_done && pending_r;
  assign in_range    = (ch >= low_limit_i) && (ch <= high_limit_i);
  assign emit        = char_formed && !error_r && in_range;
  assign err_set     = char_formed && !error_r && !in_range;

  // Build the result; a partial codeword at line end is an error
  always_comb begin
    has_result_o        = emit || item_i.line_end;
    result_o.char_valid = emit;
    result_o.out_char   = emit ? ch : '0;
    result_o.line_done  = item_i.line_end;
    result_o.line_error = item_i.line_end && (error_r || err_set || !word_done);
  end

  // Next line state
  always_comb begin
    bit_shift_nxt   = bit_shift_r;
    bit_count_nxt   = bit_count_r;
    high_nibble_nxt = high_nibble_r;
    pending_nxt     = pending_r;
    error_nxt       = error_r;
    if (item_i.line_end) begin
      bit_shift_nxt   = '0;
      bit_count_nxt   = '0;
      high_nibble_nxt = '0;
      pending_nxt     = 1'b0;
      error_nxt       = 1'b0;
    end else if (word_done) begin
      bit_shift_nxt = '0;
      bit_count_nxt = '0;
      if (pending_r) begin
        high_nibble_nxt = '0;
        pending_nxt     = 1'b0;
        error_nxt       = error_r || err_set;
      end else begin
        high_nibble_nxt = nib;
        pending_nxt     = 1'b1;
      end
    end else begin
      bit_shift_nxt = word[CODE_BITS-2:0];
      bit_count_nxt = count_inc;
    end
  end

  // Advance state only on a consumed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_shift_r   <= '0;
      bit_count_r   <= '0;
      high_nibble_r <= '0;
      pending_r     <= 1'b0;
      error_r       <= 1'b0;
    end else if (step_i) begin
      bit_shift_r   <= bit_shift_nxt;
      bit_count_r   <= bit_count_nxt;
      high_nibble_r <= high_nibble_nxt;
      pending_r     <= pending_nxt;
      error_r       <= error_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hamming_7_4_char_deframer.sv =====
// ----------------------------------------------------------------------------
// hamming_7_4_char_deframer
// Serial Hamming(7,4) decoder that packs nibble pairs into characters.
//
//   channel  dir  payload                                         handshake
//   in_ch    in   code_bit, line_end                              valid/ready
//   out_ch   out  char_valid, out_char, line_done, line_error     valid/ready
//   cfg      in   cfg_idx, cfg_wdata (char low / high limit)      cfg_we
//
// One bit per cycle while the result register is not stalled; a result passes
// through the input register and the result register around the decode logic.
// Items that produce no result leave the input register without waiting
// on the result side; a full, stalled result register stops the input.
// Reset is synchronous: the line state clears and the limits go to 32/127.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hamming_7_4_char_deframer_macros.svh"

module hamming_7_4_char_deframer
  import h74cd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  h74cd_in_if.sink           in_ch,
  h74cd_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_idx,
  input  logic [CHAR_BITS-1:0] cfg_wdata
);

  char_t   low_limit_r;
  char_t   high_limit_r;
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;

  logic    out_free;
  logic    has_result;
  result_t result;
  logic    step;
  logic    in_ready;
  cfg_reg_t cfg_reg;

  // Configuration registers
  assign cfg_reg = cfg_reg_t'(cfg_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r  <= LOW_LIMIT_RESET;
      high_limit_r <= HIGH_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg)
        REG_CHAR_LOW:  low_limit_r  <= cfg_wdata;
        REG_CHAR_HIGH: high_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the input register unless its result finds the output full
  assign out_free = !out_valid_r || out_ch.ready;
  assign step     = s1_valid_r && (!has_result || out_free);
  assign in_ready = !s1_valid_r || step;

  assign in_ch.ready = in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_item_r.code_bit <= in_ch.code_bit;
      s1_item_r.line_end <= in_ch.line_end;
    end
  end

  h74cd_framer u_framer (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_i       (step),
    .item_i       (s1_item_r),
    .low_limit_i  (low_limit_r),
    .high_limit_i (high_limit_r),
    .has_result_o (has_result),
    .result_o     (result)
  );

  // Result register: load a new result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      out_res_r <= result;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.char_valid = out_res_r.char_valid;
  assign out_ch.out_char   = out_res_r.out_char;
  assign out_ch.line_done  = out_res_r.line_done;
  assign out_ch.line_error = out_res_r.line_error;

  // A result without line end always carries a character
  `H74CD_ASSERT_IMP(a_res_has_content, clk, rst_n,
    out_valid_r && !out_res_r.line_done, out_res_r.char_valid)
  // Line error only on a closing result
  `H74CD_ASSERT_IMP(a_err_at_end, clk, rst_n,
    out_valid_r && !out_res_r.line_done, !out_res_r.line_error)
  // No character code without a character
  `H74CD_ASSERT_IMP(a_char_zero, clk, rst_n,
    out_valid_r && !out_res_r.char_valid, out_res_r.out_char == '0)
  // A produced result is presented in the next cycle
  `H74CD_ASSERT_NXT(a_res_loaded, clk, rst_n, step && has_result, out_valid_r)
  // A result never overwrites one still waiting
  `H74CD_ASSERT_IMP(a_no_overrun, clk, rst_n,
    step && has_result && out_valid_r, out_ch.ready)

endmodule

`default_nettype wire
